>>> src/windowed_register_machine_execute_unit_defines.svh
// assertion macros for the windowed register machine execute unit
`ifndef WINDOWED_REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define WINDOWED_REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WRME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define WRME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wrme_pkg.sv
// shared constants, codes and types of the windowed register machine execute unit
package wrme_pkg;

  // storage sizes
  localparam int REG_DEPTH   = 1024;
  localparam int RF_AW       = $clog2(REG_DEPTH);
  localparam int HW_W        = $clog2(REG_DEPTH + 1);
  localparam int REG_W       = 8;
  localparam int SUM_W       = ((HW_W > REG_W) ? HW_W : REG_W) + 1;
  localparam int STACK_DEPTH = 64;
  localparam int SK_AW       = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int MAX_ARGS    = 32;

  // field widths
  localparam int OP_W       = 5;
  localparam int TGT_W      = 12;
  localparam int LEN_W      = 13;
  localparam int PC_W       = LEN_W;
  localparam int POS_W      = 5;
  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int IDX_W      = 10;
  localparam int ERR_W      = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_MOVREG = 5'd0;
  localparam logic [OP_W-1:0] OP_MOVIMM = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL    = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV    = 5'd5;
  localparam logic [OP_W-1:0] OP_MOD    = 5'd6;
  localparam logic [OP_W-1:0] OP_LT     = 5'd7;
  localparam logic [OP_W-1:0] OP_GT     = 5'd8;
  localparam logic [OP_W-1:0] OP_LE     = 5'd9;
  localparam logic [OP_W-1:0] OP_GE     = 5'd10;
  localparam logic [OP_W-1:0] OP_EQ     = 5'd11;
  localparam logic [OP_W-1:0] OP_JZ     = 5'd12;
  localparam logic [OP_W-1:0] OP_JNZ    = 5'd13;
  localparam logic [OP_W-1:0] OP_JMP    = 5'd14;
  localparam logic [OP_W-1:0] OP_ARG    = 5'd15;
  localparam logic [OP_W-1:0] OP_CALL   = 5'd16;
  localparam logic [OP_W-1:0] OP_RET    = 5'd17;

  // stop codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_REG   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STACK = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_PC = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN = 4'd1;

  // one saved frame
  typedef struct packed {
    logic [PC_W-1:0]  ret_pc;
    logic [HW_W-1:0]  base;
    logic [REG_W-1:0] dst;
    logic             has;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
    logic mul_start;
    logic mul_step;
    logic div_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic long_mul;
    logic long_div;
    logic mul_done;
    logic div_done;
    logic out_free;
  } status_t;

  // raise a high-water mark to one past an absolute index
  function automatic logic [HW_W-1:0] raise_hw(input logic [HW_W-1:0] hw,
                                               input logic [SUM_W-1:0] a);
    logic [SUM_W-1:0] a1;
    a1 = a + 1'b1;
    if (a1 > SUM_W'(hw)) return HW_W'(a1);
    return hw;
  endfunction

endpackage

>>> src/wrme_ctrl.sv
// controller state machine of the execute unit
module wrme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  wrme_pkg::status_t st_i,
  output wrme_pkg::cmd_t    cmd_o,
  output logic              in_ready_o
);
  import wrme_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (st_i.long_mul) begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_MUL;
        end else if (st_i.long_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (st_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (st_i.mul_done) state_d = ST_FIN;
      end
      ST_DIV: begin
        if (st_i.div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (st_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

endmodule

>>> src/wrme_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
module wrme_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wrme_pkg::DATA_W-1:0] dividend_i,
  input  logic [wrme_pkg::DATA_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [wrme_pkg::DATA_W-1:0] quo_o,
  output logic [wrme_pkg::DATA_W-1:0] rem_o
);
  import wrme_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DATA_W:0]   shifted, diff;
  logic              ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = !diff[DATA_W];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> src/wrme_dpath.sv
// datapath: register file, frame stack, machine state, alu and output register
module wrme_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wrme_pkg::cmd_t                  cmd_i,
  output wrme_pkg::status_t               st_o,
  input  logic [wrme_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [wrme_pkg::OP_W-1:0]       in_op_i,
  input  logic                            cfg_valid_i,
  input  logic [wrme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wrme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [wrme_pkg::OUT_DATA_W-1:0] out_data_o
);
  import wrme_pkg::*;

  // input fields
  logic [REG_W-1:0]  in_dst, in_s1, in_s2;
  logic [DATA_W-1:0] in_imm;
  logic [TGT_W-1:0]  in_tgt;
  logic [POS_W-1:0]  in_pos;
  logic              in_has;

  assign in_dst = in_data_i[7:0];
  assign in_s1  = in_data_i[15:8];
  assign in_s2  = in_data_i[23:16];
  assign in_imm = in_data_i[87:24];
  assign in_tgt = in_data_i[99:88];
  assign in_pos = in_data_i[104:100];
  assign in_has = in_data_i[105];

  // machine state
  logic [PC_W-1:0]  pc_q, len_q;
  logic [HW_W-1:0]  fb_q, hw_q;
  logic [SP_W-1:0]  sp_q;
  logic             halted_q;
  logic [ERR_W-1:0] stop_q;
  logic [RF_AW-1:0] clr_q;

  // latched item
  logic [OP_W-1:0]   op_q;
  logic [REG_W-1:0]  dst_q, s1_q, s2_q;
  logic [DATA_W-1:0] imm_q;
  logic [TGT_W-1:0]  tgt_q;
  logic [POS_W-1:0]  pos_q;
  logic              has_q;

  // memories and their read data
  logic [DATA_W-1:0] rf_mem [REG_DEPTH];
  frame_t            stk_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  frame_t            stk_q;

  // read address selection at accept
  logic [OP_W-1:0]  ld_op;
  logic [SUM_W-1:0] ld_sum_a;
  logic [RF_AW-1:0] ld_ra, ld_rb;

  always_comb begin
    ld_op = (pc_q >= len_q) ? OP_RET : in_op_i;
    if (ld_op == OP_JZ || ld_op == OP_JNZ) ld_sum_a = SUM_W'(fb_q) + SUM_W'(in_dst);
    else if (ld_op == OP_RET)              ld_sum_a = SUM_W'(fb_q);
    else                                   ld_sum_a = SUM_W'(fb_q) + SUM_W'(in_s1);
    ld_ra = ld_sum_a[RF_AW-1:0];
    ld_rb = RF_AW'(SUM_W'(fb_q) + SUM_W'(in_s2));
  end

  // execute evaluation
  logic [SUM_W-1:0]  a_s1, a_s2, a_d, a_r, slot;
  logic              ok_s1, ok_s2, ok_d;
  logic [HW_W-1:0]   hw_a;
  logic [ERR_W-1:0]  err_c;
  logic              done_c, wv_c, push_c;
  logic [RF_AW-1:0]  widx_c;
  logic [DATA_W-1:0] wval_c, alu_c;
  logic [PC_W-1:0]   next_c;
  logic [HW_W-1:0]   hw_c, fb_c;
  logic [SP_W-1:0]   sp_c;

  always_comb begin
    a_s1  = SUM_W'(fb_q) + SUM_W'(s1_q);
    a_s2  = SUM_W'(fb_q) + SUM_W'(s2_q);
    a_d   = SUM_W'(fb_q) + SUM_W'(dst_q);
    a_r   = SUM_W'(stk_q.base) + SUM_W'(stk_q.dst);
    ok_s1 = a_s1 < SUM_W'(REG_DEPTH);
    ok_s2 = a_s2 < SUM_W'(REG_DEPTH);
    ok_d  = a_d < SUM_W'(REG_DEPTH);
    hw_a  = raise_hw(hw_q, a_s1);
    slot  = SUM_W'(hw_a) + SUM_W'(pos_q) - 1'b1;

    // short alu results
    case (op_q)
      OP_ADD:  alu_c = rd_a_q + rd_b_q;
      OP_SUB:  alu_c = rd_a_q - rd_b_q;
      OP_LT:   alu_c = DATA_W'($signed(rd_a_q) < $signed(rd_b_q));
      OP_GT:   alu_c = DATA_W'($signed(rd_b_q) < $signed(rd_a_q));
      OP_LE:   alu_c = DATA_W'(!($signed(rd_b_q) < $signed(rd_a_q)));
      OP_GE:   alu_c = DATA_W'(!($signed(rd_a_q) < $signed(rd_b_q)));
      OP_EQ:   alu_c = DATA_W'(rd_a_q == rd_b_q);
      default: alu_c = '0;
    endcase

    err_c  = ERR_NONE;
    done_c = 1'b0;
    wv_c   = 1'b0;
    push_c = 1'b0;
    widx_c = a_d[RF_AW-1:0];
    wval_c = '0;
    next_c = pc_q + 1'b1;
    hw_c   = hw_q;
    fb_c   = fb_q;
    sp_c   = sp_q;

    case (op_q)
      OP_MOVIMM: begin
        wval_c = imm_q;
        if (!ok_d) err_c = ERR_REG;
        else begin
          wv_c = 1'b1;
          hw_c = raise_hw(hw_q, a_d);
        end
      end
      OP_MOVREG: begin
        wval_c = rd_a_q;
        if (!ok_s1 || !ok_d) err_c = ERR_REG;
        else begin
          wv_c = 1'b1;
          hw_c = raise_hw(hw_a, a_d);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ: begin
        wval_c = alu_c;
        if (!ok_s1 || !ok_s2) err_c = ERR_REG;
        else if ((op_q == OP_DIV || op_q == OP_MOD) && rd_b_q == '0) err_c = ERR_DIV0;
        else if (!ok_d) err_c = ERR_REG;
        else begin
          wv_c = 1'b1;
          hw_c = raise_hw(raise_hw(hw_a, a_s2), a_d);
        end
      end
      OP_JZ, OP_JNZ: begin
        if (!ok_d) err_c = ERR_REG;
        else begin
          hw_c = raise_hw(hw_q, a_d);
          if ((rd_a_q == '0) == (op_q == OP_JZ)) next_c = PC_W'(tgt_q);
        end
      end
      OP_JMP: next_c = PC_W'(tgt_q);
      OP_ARG: begin
        next_c = pc_q;
        if (pos_q != '0 && {1'b0, pos_q} < (POS_W + 1)'(MAX_ARGS)) begin
          if (!ok_s1 || slot >= SUM_W'(REG_DEPTH)) err_c = ERR_REG;
          else begin
            wv_c   = 1'b1;
            widx_c = slot[RF_AW-1:0];
            wval_c = rd_a_q;
            hw_c   = hw_a;
          end
        end
      end
      OP_CALL: begin
        if (sp_q >= SP_W'(STACK_DEPTH)) err_c = ERR_STACK;
        else begin
          push_c = 1'b1;
          sp_c   = sp_q + 1'b1;
          fb_c   = hw_q;
          next_c = PC_W'(tgt_q);
        end
      end
      OP_RET: begin
        if (sp_q == '0) begin
          done_c = 1'b1;
          next_c = pc_q;
        end else begin
          sp_c   = sp_q - 1'b1;
          hw_c   = fb_q;
          fb_c   = stk_q.base;
          next_c = stk_q.ret_pc;
          if (stk_q.has) begin
            if (a_r >= SUM_W'(REG_DEPTH)) err_c = ERR_REG;
            else begin
              wv_c   = 1'b1;
              widx_c = a_r[RF_AW-1:0];
              wval_c = (fb_q < HW_W'(REG_DEPTH)) ? rd_a_q : '0;
              hw_c   = raise_hw(fb_q, a_r);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // shared 32x32 multiplier over three partial products
  logic [1:0]        mcnt_q;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [DATA_W-1:0] prod_q, acc_q;

  always_comb begin
    if (cmd_i.mul_start) begin
      mul_x = rd_a_q[HALF_W-1:0];
      mul_y = rd_b_q[HALF_W-1:0];
    end else if (mcnt_q == 2'd1) begin
      mul_x = rd_a_q[HALF_W-1:0];
      mul_y = rd_b_q[DATA_W-1:HALF_W];
    end else begin
      mul_x = rd_a_q[DATA_W-1:HALF_W];
      mul_y = rd_b_q[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mcnt_q <= '0;
    else if (cmd_i.mul_start) mcnt_q <= 2'd1;
    else if (cmd_i.mul_step && mcnt_q != 2'd3) mcnt_q <= mcnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start || cmd_i.mul_step) prod_q <= mul_x * mul_y;
    if (cmd_i.mul_step) begin
      if (mcnt_q == 2'd1) acc_q <= prod_q;
      else                acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  // divider on magnitudes
  logic [DATA_W-1:0] mag_a, mag_b, quo, rem, quo_fix, rem_fix;
  logic              div_done;

  assign mag_a = rd_a_q[DATA_W-1] ? (DATA_W'(0) - rd_a_q) : rd_a_q;
  assign mag_b = rd_b_q[DATA_W-1] ? (DATA_W'(0) - rd_b_q) : rd_b_q;

  wrme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign quo_fix = (rd_a_q[DATA_W-1] ^ rd_b_q[DATA_W-1]) ? (DATA_W'(0) - quo) : quo;
  assign rem_fix = rd_a_q[DATA_W-1] ? (DATA_W'(0) - rem) : rem;

  // final write value
  logic [DATA_W-1:0] wval_f;

  always_comb begin
    case (op_q)
      OP_MUL:  wval_f = acc_q;
      OP_DIV:  wval_f = quo_fix;
      OP_MOD:  wval_f = rem_fix;
      default: wval_f = wval_c;
    endcase
  end

  // result beat
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  commit_ok;

  assign commit_ok = cmd_i.commit && !halted_q && err_c == ERR_NONE && !done_c;

  always_comb begin
    out_data_d = '0;
    if (halted_q) begin
      out_data_d[11:0]  = pc_q[11:0];
      out_data_d[12]    = (stop_q == ERR_NONE);
      out_data_d[14:13] = stop_q;
    end else if (err_c != ERR_NONE) begin
      out_data_d[11:0]  = pc_q[11:0];
      out_data_d[14:13] = err_c;
    end else if (done_c) begin
      out_data_d[11:0] = pc_q[11:0];
      out_data_d[12]   = 1'b1;
    end else begin
      out_data_d[11:0] = next_c[11:0];
      out_data_d[15]   = wv_c;
      if (wv_c) begin
        out_data_d[25:16] = IDX_W'(widx_c);
        out_data_d[89:26] = wval_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // register file: clearing pass, commit write, two registered reads
  logic              rf_we;
  logic [RF_AW-1:0]  rf_wa;
  logic [DATA_W-1:0] rf_wd;

  assign rf_we = cmd_i.clear || (commit_ok && wv_c);
  assign rf_wa = cmd_i.clear ? clr_q : widx_c;
  assign rf_wd = cmd_i.clear ? '0 : wval_f;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (cmd_i.load) begin
      rd_a_q <= rf_mem[ld_ra];
      rd_b_q <= rf_mem[ld_rb];
    end
  end

  // frame stack
  frame_t push_entry;

  always_comb begin
    push_entry.ret_pc = pc_q + 1'b1;
    push_entry.base   = fb_q;
    push_entry.dst    = dst_q;
    push_entry.has    = has_q;
  end

  always_ff @(posedge clk_i) begin
    if (commit_ok && push_c) stk_mem[sp_q[SK_AW-1:0]] <= push_entry;
    if (cmd_i.load) stk_q <= stk_mem[SK_AW'(sp_q - 1'b1)];
  end

  // latch item at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= ld_op;
      dst_q <= in_dst;
      s1_q  <= in_s1;
      s2_q  <= in_s2;
      imm_q <= in_imm;
      tgt_q <= in_tgt;
      pos_q <= in_pos;
      has_q <= in_has;
    end
  end

  // machine state, configuration and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      len_q    <= '0;
      fb_q     <= '0;
      hw_q     <= '0;
      sp_q     <= '0;
      halted_q <= 1'b0;
      stop_q   <= ERR_NONE;
      clr_q    <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit && !halted_q) begin
        if (err_c != ERR_NONE) begin
          halted_q <= 1'b1;
          stop_q   <= err_c;
        end else if (done_c) begin
          halted_q <= 1'b1;
          stop_q   <= ERR_NONE;
        end else begin
          pc_q <= next_c;
          fb_q <= fb_c;
          hw_q <= hw_c;
          sp_q <= sp_c;
        end
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ENTRY_PC: pc_q  <= PC_W'(cfg_data_i[TGT_W-1:0]);
          CFG_PROG_LEN: len_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // status
  always_comb begin
    st_o.clear_last = (clr_q == RF_AW'(REG_DEPTH - 1));
    st_o.long_mul   = !halted_q && err_c == ERR_NONE && op_q == OP_MUL;
    st_o.long_div   = !halted_q && err_c == ERR_NONE && (op_q == OP_DIV || op_q == OP_MOD);
    st_o.mul_done   = (mcnt_q == 2'd3);
    st_o.div_done   = div_done;
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

>>> src/windowed_register_machine_execute_unit.sv
// Instructions other than mul, div and mod pass through accept and execute, then commit.
// Mul forms three 32x32 partial products through one shared multiplier.
// Div and mod run on the divider, which yields one quotient bit per cycle.
// Only one instruction is in flight; the next one is taken after the result is loaded.
// Reset: control state clears at once, then a clearing pass zeroes the register file,
// during which no instruction is taken; configuration writes are taken at any time.
module windowed_register_machine_execute_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // dst_reg, src1_reg, src2_reg, immediate, target_pc, arg_position, has_result_reg
  input  logic [wrme_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic [wrme_pkg::OP_W-1:0]       s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // next_pc, done_res, error_code, write_valid, write_index, write_value
  output logic [wrme_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wrme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wrme_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wrme_pkg::*;
  `include "windowed_register_machine_execute_unit_defines.svh"

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  // controller
  wrme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o)
  );

  // datapath
  wrme_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (s_axis_tdata_i),
    .in_op_i     (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  // checks
  `WRME_ASSERT_NOW(a_no_take_in_clear, cmd.clear, !s_axis_tready_o, "beat taken during clear")
  `WRME_ASSERT_NEXT(a_commit_shows, cmd.commit, m_axis_tvalid_o, "result beat not presented")
  `WRME_ASSERT_NEXT(a_one_in_flight, cmd.load, !s_axis_tready_o, "second beat taken in flight")

endmodule
